// ===== rtl/hgid_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hgid_pkg
// Sizes, constants and types of the hash group id assigner.
// ----------------------------------------------------------------------------
package hgid_pkg;

  // Table geometry
  localparam int MAX_SLOT_BITS = 12;
  localparam int MIN_SLOT_BITS = 5;
  localparam int MAX_SLOTS     = 1 << MAX_SLOT_BITS;
  localparam int MAX_GROUPS    = 3 << (MAX_SLOT_BITS - 2);
  localparam int SLOT_BITS_W   = 4;
  localparam logic [SLOT_BITS_W-1:0] SLOT_BITS_RESET = SLOT_BITS_W'(MAX_SLOT_BITS);

  // Group ids are one-based and fit the slot entry as is
  localparam int GID_W   = 12;
  localparam int IDX_W   = MAX_SLOT_BITS;
  localparam int PROBE_W = MAX_SLOT_BITS + 1;

  // Payload widths
  localparam int KEY_WIDTH = 64;
  localparam int ROW_WIDTH = 32;
  localparam int HASH_W    = 32;
  localparam int FIRST_W   = 32;

  // Group store entry: first row above key
  localparam int GRP_W = KEY_WIDTH + ROW_WIDTH;

  // Input mode codes
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_CLEAR  = 1'b1;

  // Sequencer states
  typedef enum logic [5:0] {
    ST_SWEEP    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_SLOT_RD  = 6'b000100,
    ST_SLOT_CHK = 6'b001000,
    ST_GRP_CHK  = 6'b010000,
    ST_DONE     = 6'b100000
  } state_t;

endpackage

// ===== rtl/hash_group_id_assigner.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_group_id_assigner
// Dense one-based group numbering of rows by an open-addressed slot table
// with triangular probing.
// ----------------------------------------------------------------------------
// Rows are handled one at a time by a read-modify-write sequencer around two
// single-port-read synchronous memories: the slot table (4096 x 12) and the
// group store (3072 x 96, key plus first row). A row whose first probe hits an
// empty slot passes slot read and slot check; each occupied slot passed over
// adds a group store read and key compare, then a new slot read, and a row
// matching at its first probe ends after its key compare. A full probe sweep
// with no result ends in overflow. After reset and after every clear request
// the slot table is swept one slot per cycle over all 4096 slots while no row
// is accepted; configuration writes are taken at any time. The result of a
// clear is given after its sweep. A result register decouples the output: a
// new row is accepted while the previous result waits to be taken.
// ----------------------------------------------------------------------------
module hash_group_id_assigner
  import hgid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [SLOT_BITS_W-1:0] slot_bits,
  // rows in
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  logic [HASH_W-1:0]      key_hash,
  input  logic [63:0]            row_key,
  // results out
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [GID_W-1:0]       group_id,
  output logic                   new_group,
  output logic [FIRST_W-1:0]     first_row,
  output logic                   overflow
);

  // Memories
  logic [GID_W-1:0] slot_mem [0:MAX_SLOTS-1];
  logic [GRP_W-1:0] grp_mem  [0:MAX_GROUPS-1];

  state_t                 state;
  logic [SLOT_BITS_W-1:0] slot_bits_reg;
  logic [IDX_W-1:0]       sweep_addr;
  logic                   sweep_reply;
  logic [GID_W-1:0]       group_count;
  logic [ROW_WIDTH-1:0]   row_counter;
  logic [KEY_WIDTH-1:0]   key_reg;
  logic [IDX_W-1:0]       probe_idx;
  logic [PROBE_W-1:0]     probe_n;
  logic [GID_W-1:0]       entry_reg;
  logic                   entry_ok;

  logic [GID_W-1:0]       slot_q;
  logic [GRP_W-1:0]       grp_q;

  logic [GID_W-1:0]       res_gid;
  logic                   res_new;
  logic [FIRST_W-1:0]     res_first;
  logic                   res_ovf;

  // Derived configuration
  logic [SLOT_BITS_W-1:0] act_bits;
  logic [IDX_W-1:0]       mask;
  logic [GID_W-1:0]       cap;
  logic [PROBE_W-1:0]     slots;
  logic [PROBE_W-1:0]     probe_n_next;
  logic                   cap_full;
  logic                   key_hit;

  logic                   slot_we;
  logic [IDX_W-1:0]       slot_waddr;
  logic [GID_W-1:0]       slot_wdata;
  logic                   grp_we;
  logic [GID_W-1:0]       grp_raddr;
  logic                   in_xfer;
  logic                   out_free;

  // Clamp slot_bits to the usable range and derive size, mask and capacity
  always_comb begin
    if (slot_bits_reg < SLOT_BITS_W'(MIN_SLOT_BITS)) begin
      act_bits = SLOT_BITS_W'(MIN_SLOT_BITS);
    end else if (slot_bits_reg > SLOT_BITS_W'(MAX_SLOT_BITS)) begin
      act_bits = SLOT_BITS_W'(MAX_SLOT_BITS);
    end else begin
      act_bits = slot_bits_reg;
    end
  end

  assign mask  = {IDX_W{1'b1}} >> (SLOT_BITS_W'(MAX_SLOT_BITS) - act_bits);
  assign cap   = GID_W'(MAX_GROUPS) >> (SLOT_BITS_W'(MAX_SLOT_BITS) - act_bits);
  assign slots = PROBE_W'(1) << act_bits;

  assign probe_n_next = probe_n + PROBE_W'(1);
  assign cap_full     = (group_count >= cap);
  assign key_hit      = entry_ok && (grp_q[KEY_WIDTH-1:0] == key_reg);

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;

  // Slot table write: sweep clears, insert writes the new group id
  always_comb begin
    slot_we    = 1'b0;
    slot_waddr = probe_idx;
    slot_wdata = group_count + GID_W'(1);
    if (state == ST_SWEEP) begin
      slot_we    = 1'b1;
      slot_waddr = sweep_addr;
      slot_wdata = '0;
    end else if (state == ST_SLOT_CHK && slot_q == '0 && !cap_full) begin
      slot_we = 1'b1;
    end
  end

  assign grp_we    = (state == ST_SLOT_CHK) && (slot_q == '0) && !cap_full;
  assign grp_raddr = slot_q - GID_W'(1);

  // Slot table memory
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_q <= slot_mem[probe_idx];
  end

  // Group store memory
  always_ff @(posedge clk) begin
    if (grp_we) begin
      grp_mem[group_count] <= {row_counter, key_reg};
    end
    grp_q <= grp_mem[grp_raddr];
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_bits_reg <= SLOT_BITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slot_bits_reg <= slot_bits;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      group_count <= '0;
      row_counter <= '0;
    end else begin
      unique case (state)
        ST_SWEEP: begin
          sweep_addr <= sweep_addr + IDX_W'(1);
          if (sweep_addr == {IDX_W{1'b1}}) begin
            state <= sweep_reply ? ST_DONE : ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_xfer) begin
            if (mode == MODE_CLEAR) begin
              group_count <= '0;
              row_counter <= '0;
              sweep_addr  <= '0;
              sweep_reply <= 1'b1;
              state       <= ST_SWEEP;
            end else begin
              if (row_counter != {ROW_WIDTH{1'b1}}) begin
                row_counter <= row_counter + ROW_WIDTH'(1);
              end
              state <= ST_SLOT_RD;
            end
          end
        end
        ST_SLOT_RD: begin
          state <= ST_SLOT_CHK;
        end
        ST_SLOT_CHK: begin
          if (slot_q == '0) begin
            if (!cap_full) begin
              group_count <= group_count + GID_W'(1);
            end
            state <= ST_DONE;
          end else begin
            state <= ST_GRP_CHK;
          end
        end
        ST_GRP_CHK: begin
          if (key_hit || probe_n_next == slots) begin
            state <= ST_DONE;
          end else begin
            state <= ST_SLOT_RD;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_SWEEP;
        end
      endcase
    end
  end

  // Probe datapath and result staging
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        key_reg   <= row_key[KEY_WIDTH-1:0];
        probe_idx <= key_hash[IDX_W-1:0] & mask;
        probe_n   <= '0;
        res_gid   <= '0;
        res_new   <= 1'b0;
        res_first <= '0;
        res_ovf   <= 1'b0;
      end
      ST_SLOT_CHK: begin
        entry_reg <= slot_q;
        entry_ok  <= (slot_q <= group_count);
        if (slot_q == '0) begin
          if (cap_full) begin
            res_ovf <= 1'b1;
          end else begin
            res_gid   <= group_count + GID_W'(1);
            res_new   <= 1'b1;
            res_first <= FIRST_W'(row_counter);
          end
        end
      end
      ST_GRP_CHK: begin
        if (key_hit) begin
          res_gid   <= entry_reg;
          res_first <= FIRST_W'(grp_q[GRP_W-1:KEY_WIDTH]);
        end else if (probe_n_next == slots) begin
          res_ovf <= 1'b1;
        end else begin
          probe_n   <= probe_n_next;
          probe_idx <= (probe_idx + probe_n_next[IDX_W-1:0]) & mask;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      group_id  <= res_gid;
      new_group <= res_new;
      first_row <= res_first;
      overflow  <= res_ovf;
    end
  end

endmodule

// ===== bench/hash_group_id_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_group_id_checker
// Watches the configuration, row and result channels of the group id
// assigner. Keeps its own slot table and group store, predicts the result of
// every accepted row and compares each result transfer with the oldest
// prediction.
// ----------------------------------------------------------------------------
module hash_group_id_checker
  import hgid_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [SLOT_BITS_W-1:0] slot_bits,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  logic                   mode,
  input  logic [HASH_W-1:0]      key_hash,
  input  logic [63:0]            row_key,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  logic [GID_W-1:0]       group_id,
  input  logic                   new_group,
  input  logic [FIRST_W-1:0]     first_row,
  input  logic                   overflow,
  output int unsigned            mismatches,
  output int unsigned            results_pending
);

  typedef struct packed {
    logic [GID_W-1:0]   gid;
    logic               is_new;
    logic [FIRST_W-1:0] first;
    logic               ovf;
  } group_answer_t;

  // Shadow copy of the block state
  logic [GID_W-1:0]     slot_group [MAX_SLOTS];
  logic [KEY_WIDTH-1:0] group_key [MAX_GROUPS];
  logic [FIRST_W-1:0]   group_first [MAX_GROUPS];
  int unsigned          group_total;
  logic [ROW_WIDTH-1:0] rows_seen;
  logic [SLOT_BITS_W-1:0] bits_setting;

  group_answer_t expected_groups [$];
  group_answer_t want, got;

  initial mismatches = 0;
  initial results_pending = 0;

  task automatic report_mismatch(string what);
    $display("%0t ns: result mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  function automatic void empty_table();
    for (int i = 0; i < MAX_SLOTS; i++) slot_group[i] = '0;
    group_total = 0;
    rows_seen = '0;
  endfunction

  // Look up or insert one row, or clear, and return the answer it gets
  function automatic group_answer_t predict_group(logic m, logic [HASH_W-1:0] h,
                                                  logic [KEY_WIDTH-1:0] k);
    int unsigned nbits, nslots, cap, idx;
    logic [GID_W-1:0] entry;
    group_answer_t ans;
    ans = '0;
    if (m == MODE_CLEAR) begin
      empty_table();
      return ans;
    end
    nbits = bits_setting;
    if (nbits < MIN_SLOT_BITS) nbits = MIN_SLOT_BITS;
    if (nbits > MAX_SLOT_BITS) nbits = MAX_SLOT_BITS;
    nslots = 1 << nbits;
    cap = 3 << (nbits - 2);
    // row numbers saturate instead of wrapping
    if (rows_seen != {ROW_WIDTH{1'b1}}) rows_seen = rows_seen + 1'b1;
    idx = h & (nslots - 1);
    for (int n = 0; n < nslots; n++) begin
      if (n != 0) idx = (idx + n) & (nslots - 1);
      entry = slot_group[idx];
      if (entry == '0) begin
        // empty slot: new group unless capacity is used up
        if (group_total >= cap || group_total >= MAX_GROUPS) begin
          ans.ovf = 1'b1;
          return ans;
        end
        group_key[group_total] = k;
        group_first[group_total] = FIRST_W'(rows_seen);
        group_total++;
        slot_group[idx] = GID_W'(group_total);
        ans.gid = GID_W'(group_total);
        ans.is_new = 1'b1;
        ans.first = FIRST_W'(rows_seen);
        return ans;
      end
      if (entry <= group_total && group_key[entry - 1] == k) begin
        ans.gid = entry;
        ans.first = group_first[entry - 1];
        return ans;
      end
    end
    // whole sweep without a free slot or a match
    ans.ovf = 1'b1;
    return ans;
  endfunction

  // Track transfers on all three channels
  always @(posedge clk) begin
    if (rst) begin
      empty_table();
      bits_setting = SLOT_BITS_RESET;
      expected_groups.delete();
      results_pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) bits_setting = slot_bits;
      if (in_valid && in_ready)
        expected_groups.push_back(predict_group(mode, key_hash, row_key[KEY_WIDTH-1:0]));
      if (out_valid && out_ready) begin
        got.gid = group_id;
        got.is_new = new_group;
        got.first = first_row;
        got.ovf = overflow;
        if (expected_groups.size() == 0) begin
          report_mismatch($sformatf("unexpected result, group_id %0d", got.gid));
        end else begin
          want = expected_groups.pop_front();
          if (got.gid != want.gid)
            report_mismatch($sformatf("group_id %0d, want %0d", got.gid, want.gid));
          if (got.is_new != want.is_new)
            report_mismatch($sformatf("new_group %0b, want %0b", got.is_new, want.is_new));
          if (got.first != want.first)
            report_mismatch($sformatf("first_row %0d, want %0d", got.first, want.first));
          if (got.ovf != want.ovf)
            report_mismatch($sformatf("overflow %0b, want %0b", got.ovf, want.ovf));
        end
      end
      results_pending <= expected_groups.size();
    end
  end

endmodule

// ===== bench/hash_group_id_assigner_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hash_group_id_assigner_tb
// Drives rows and slot size settings into the group id assigner: a directed
// pass over key and hash extremes, probe collisions, shrinking without clear
// and out-of-range sizes, a fill to capacity followed by a shrink, then
// random phases over every size setting with key pools and varying idling.
// ----------------------------------------------------------------------------
module hash_group_id_assigner_tb;
  import hgid_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned PHASE_ROWS  = 46;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idling_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [SLOT_BITS_W-1:0] slot_bits = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   mode = MODE_LOOKUP;
  logic [HASH_W-1:0]      key_hash = '0;
  logic [63:0]            row_key = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [GID_W-1:0]       group_id;
  logic                   new_group;
  logic [FIRST_W-1:0]     first_row;
  logic                   overflow;

  int unsigned mismatches;
  int unsigned results_pending;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned cycle_count = 0;

  hash_group_id_assigner dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .slot_bits (slot_bits),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .key_hash  (key_hash),
    .row_key   (row_key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .group_id  (group_id),
    .new_group (new_group),
    .first_row (first_row),
    .overflow  (overflow)
  );

  hash_group_id_checker scoreboard (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .slot_bits       (slot_bits),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .mode            (mode),
    .key_hash        (key_hash),
    .row_key         (row_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .group_id        (group_id),
    .new_group       (new_group),
    .first_row       (first_row),
    .overflow        (overflow),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stall the result side at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[hash_group_id_assigner] ERROR");
      $finish;
    end
  end

  task automatic set_idling(idling_t im);
    case (im)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 51; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 51; end
      default:   begin send_idle_pct = 34; recv_stall_pct = 34; end
    endcase
  endtask

  // Hold one row on the input channel until its transfer; valid stays high
  // across back-to-back rows
  task automatic send_row(logic m, logic [HASH_W-1:0] h, logic [63:0] k);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    mode     <= m;
    key_hash <= h;
    row_key  <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_slot_bits(logic [SLOT_BITS_W-1:0] value);
    cfg_valid <= 1'b1;
    slot_bits <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Drop valid and wait for every outstanding result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [KEY_WIDTH-1:0] fill_key [48];
    logic [HASH_W-1:0]    fill_hash [48];
    int unsigned          pick;
    int unsigned          bits_plan [18] = '{5, 0, 12, 15, 6, 4, 7, 13, 5, 9, 3, 8,
                                             14, 1, 10, 2, 11, 5};

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: key and hash extremes, collisions on one start slot
    set_idling(IDLE_NONE);
    write_slot_bits(SLOT_BITS_W'(6));
    send_row(MODE_LOOKUP, '0, '0);
    send_row(MODE_LOOKUP, '0, '0);
    send_row(MODE_LOOKUP, '1, '1);
    send_row(MODE_LOOKUP, '0, 64'd1);
    send_row(MODE_LOOKUP, '0, 64'd1);
    send_row(MODE_LOOKUP, '0, 64'h8000_0000_0000_0000);
    send_row(MODE_LOOKUP, 32'd40, 64'hA5A5_5A5A_0F0F_F0F0);
    drain_results();

    // Shrink without clear: upper entries drop out of sight and count again
    write_slot_bits(SLOT_BITS_W'(5));
    send_row(MODE_LOOKUP, 32'd40, 64'hA5A5_5A5A_0F0F_F0F0);
    send_row(MODE_LOOKUP, '1, '1);
    send_row(MODE_LOOKUP, '0, '0);
    send_row(MODE_CLEAR, '1, '1);
    drain_results();

    // Sizes below and above the usable range
    write_slot_bits('0);
    send_row(MODE_LOOKUP, 32'd33, 64'h1234_5678_9ABC_DEF0);
    drain_results();
    write_slot_bits('1);
    send_row(MODE_LOOKUP, 32'd33, 64'h1234_5678_9ABC_DEF0);
    send_row(MODE_LOOKUP, 32'd1, 64'h1234_5678_9ABC_DEF0);
    drain_results();

    // Fill the 64-slot table to its capacity of 48 groups, then shrink so a sweep finds no free slot
    set_idling(IDLE_BOTH);
    write_slot_bits(SLOT_BITS_W'(6));
    send_row(MODE_CLEAR, $urandom(), {$urandom(), $urandom()});
    for (int i = 0; i < 48; i++) begin
      fill_key[i] = {$urandom(), $urandom()};
      fill_hash[i] = {26'($urandom()), 6'(i)};
      send_row(MODE_LOOKUP, fill_hash[i], fill_key[i]);
    end
    send_row(MODE_LOOKUP, $urandom(), {$urandom(), $urandom()});
    repeat (4) begin
      pick = $urandom_range(0, 47);
      send_row(MODE_LOOKUP, fill_hash[pick], fill_key[pick]);
    end
    drain_results();
    write_slot_bits(SLOT_BITS_W'(5));
    repeat (2) send_row(MODE_LOOKUP, $urandom(), {$urandom(), $urandom()});
    repeat (4) begin
      pick = $urandom_range(0, 31);
      send_row(MODE_LOOKUP, fill_hash[pick], fill_key[pick]);
    end
    drain_results();

    // Random phases: one size setting each, rows drawn from a key pool
    for (int p = 0; p < 18; p++) begin
      logic [KEY_WIDTH-1:0] pool_key [$];
      logic [HASH_W-1:0]    pool_hash [$];
      logic [HASH_W-1:0]    h;
      int unsigned          pool_n, roll;
      bit                   clustered;
      // start every phase with a fresh pool
      pool_key.delete();
      pool_hash.delete();
      set_idling(idling_t'(p % 4));
      write_slot_bits(SLOT_BITS_W'(bits_plan[p]));
      clustered = $urandom_range(0, 1);
      pool_n = $urandom_range(4, 60);
      // clustered pools share low hash bits and build long probe chains
      for (int i = 0; i < pool_n; i++) begin
        h = $urandom();
        if (clustered) h[4:0] = 5'($urandom_range(0, 3));
        pool_hash.push_back(h);
        pool_key.push_back({$urandom(), $urandom()});
      end
      if ($urandom_range(0, 1)) send_row(MODE_CLEAR, $urandom(), {$urandom(), $urandom()});
      repeat (PHASE_ROWS) begin
        roll = $urandom_range(0, 99);
        pick = $urandom_range(0, pool_n - 1);
        if (roll < 2)
          send_row(MODE_CLEAR, $urandom(), {$urandom(), $urandom()});
        else if (roll < 6)
          send_row(MODE_LOOKUP, $urandom(), {$urandom(), $urandom()});
        else if (roll < 10)
          send_row(MODE_LOOKUP, $urandom(), pool_key[pick]);
        else
          send_row(MODE_LOOKUP, pool_hash[pick], pool_key[pick]);
      end
      drain_results();
    end

    repeat (32) @(posedge clk);
    if (mismatches == 0 && results_pending == 0)
      $display("[hash_group_id_assigner] OK");
    else
      $display("[hash_group_id_assigner] ERROR");
    $finish;
  end

endmodule
